[hw/rtl/cpf_pkg.sv]
package cpf_pkg;

    // packet geometry
    localparam int PACKET_LEN   = 10;
    localparam int FILL_W       = $clog2(PACKET_LEN);
    localparam int REPORT_BYTES = 9;

    // reflected crc-8, lsb first
    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [7:0] CRC_INIT = 8'h00;

    // configuration registers
    localparam int         CFG_IDX_W    = 1;
    localparam logic [0:0] CFG_MIN_ID   = 1'b0;
    localparam logic [0:0] CFG_MAX_ID   = 1'b1;
    localparam logic [7:0] MIN_ID_RESET = 8'h01;
    localparam logic [7:0] MAX_ID_RESET = 8'h04;

    typedef logic [7:0] byte_t;

    // control from the sequencer to the crc unit
    typedef struct packed {
        logic clear;
        logic step;
        logic mix;
    } crc_ctrl_t;

    // one bit of the reflected crc shift
    function automatic byte_t crc_bit_step(input byte_t c);
        byte_t r;
        r = {1'b0, c[7:1]};
        if (c[0])
        begin
            r = r ^ CRC_POLY;
        end
        return r;
    endfunction

endpackage

[hw/rtl/cpf_cell.sv]
module cpf_cell (
    input  logic          clk,
    input  logic          en,
    input  cpf_pkg::byte_t d,
    output cpf_pkg::byte_t q
);
    import cpf_pkg::*;

    byte_t data_reg;

    // one window byte, loaded from its neighbour
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

[hw/rtl/cpf_crc.sv]
module cpf_crc (
    input  logic              clk,
    input  logic              rst_n,
    input  cpf_pkg::crc_ctrl_t ctrl,
    input  cpf_pkg::byte_t     data_in,
    output cpf_pkg::byte_t     crc
);
    import cpf_pkg::*;

    byte_t crc_reg;
    byte_t crc_next;
    byte_t crc_mixed;

    // fold the new byte in on its first bit, then shift one bit a cycle while step is set
    always_comb
    begin
        crc_mixed = ctrl.mix ? (crc_reg ^ data_in) : crc_reg;
        crc_next  = crc_reg;
        if (ctrl.clear)
        begin
            crc_next = CRC_INIT;
        end
        else if (ctrl.step)
        begin
            crc_next = crc_bit_step(crc_mixed);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

[hw/rtl/crc8_checked_packet_framer.sv]
// Fixed-length packet framer with a reflected CRC-8 check (poly 0x8C, init 0).
// Input channel: one received byte per beat on rx_byte (in_valid / in_stall).
// Output channel: one beat per accepted packet carrying the id, payload
// words, check byte and signed speed (out_valid / out_stall).
// Configuration: cfg_we writes cfg_data into min_id (index 0) or max_id
// (index 1); write only while the framer is idle.
// The window is a row of byte cells shifting toward the oldest end. A beat
// that does not fill the window is taken without stall while the framer is
// idle, back to back. A beat that fills it starts a check: the cells rotate
// past a bit-serial CRC unit one data byte at a time, then a restore step puts
// back the order and a decide step judges the packet. in_stall stays high
// through the crc, restore and decide states; decide registers a passing result.
// A held result does not block input; only a beat that would fill the window
// again is stalled until the result is taken. When the check fails the oldest
// byte drops out and the framer resynchronises one byte at a time.
// Reset empties the window, clears out_valid and loads min_id 1, max_id 4.
module crc8_checked_packet_framer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     device_id,
    output logic [31:0]                    payload_front,
    output logic [31:0]                    payload_back,
    output logic [7:0]                     check_byte,
    output logic signed [15:0]             speed_value
);
    import cpf_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_CRC     = 2'd1;
    localparam logic [1:0] ST_RESTORE = 2'd2;
    localparam logic [1:0] ST_DECIDE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [2:0]        bit_reg, bit_next;
    logic [FILL_W-1:0] byte_cnt_reg, byte_cnt_next;
    byte_t             min_id_reg, max_id_reg;
    logic              out_valid_reg, out_valid_next;
    byte_t             dev_id_reg;
    logic [31:0]       front_reg, back_reg;
    byte_t             check_reg;
    logic [15:0]       speed_reg;

    logic      accept;
    logic      fills;
    logic      rotate;
    logic      cell_en;
    logic      pass;
    byte_t     tail_in;
    byte_t     crc;
    crc_ctrl_t crc_ctrl;
    byte_t     cell_q    [PACKET_LEN];
    byte_t     data_win  [REPORT_BYTES];

    // handshake
    assign fills    = (fill_reg == FILL_W'(PACKET_LEN - 1));
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && fills);
    assign accept   = in_valid && !in_stall;

    // cell chain: shift in on a beat, rotate during the check
    assign rotate  = ((state_reg == ST_CRC) && (bit_reg == 3'd7))
                  || (state_reg == ST_RESTORE);
    assign cell_en = accept || rotate;
    assign tail_in = (state_reg == ST_IDLE) ? rx_byte : cell_q[0];

    for (genvar i = 0; i < PACKET_LEN; i++)
    begin : g_cell
        byte_t d;
        if (i == PACKET_LEN - 1)
        begin : g_tail
            assign d = tail_in;
        end
        else
        begin : g_body
            assign d = cell_q[i+1];
        end
        cpf_cell u_cell (
            .clk (clk),
            .en  (cell_en),
            .d   (d),
            .q   (cell_q[i])
        );
    end

    // crc over the oldest cell as it passes
    assign crc_ctrl.clear = accept && fills;
    assign crc_ctrl.step  = (state_reg == ST_CRC);
    assign crc_ctrl.mix   = (bit_reg == 3'd0);

    cpf_crc u_crc (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (crc_ctrl),
        .data_in (cell_q[0]),
        .crc     (crc)
    );

    // reported data bytes, zero past the last data byte
    for (genvar k = 0; k < REPORT_BYTES; k++)
    begin : g_win
        if (k < PACKET_LEN - 1)
        begin : g_data
            assign data_win[k] = cell_q[k];
        end
        else
        begin : g_zero
            assign data_win[k] = '0;
        end
    end

    assign pass = (cell_q[0] >= min_id_reg) && (cell_q[0] <= max_id_reg)
               && (crc == cell_q[PACKET_LEN-1]);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        bit_next       = bit_reg;
        byte_cnt_next  = byte_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (fills)
                    begin
                        state_next    = ST_CRC;
                        bit_next      = '0;
                        byte_cnt_next = '0;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            ST_CRC:
            begin
                bit_next = bit_reg + 1'b1;
                if (bit_reg == 3'd7)
                begin
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                    if (byte_cnt_reg == FILL_W'(PACKET_LEN - 2))
                    begin
                        state_next = ST_RESTORE;
                    end
                end
            end
            ST_RESTORE:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
                if (pass)
                begin
                    fill_next      = '0;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bit_reg       <= '0;
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bit_reg       <= bit_next;
            byte_cnt_reg  <= byte_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_id_reg <= MIN_ID_RESET;
            max_id_reg <= MAX_ID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_ID: min_id_reg <= cfg_data;
                CFG_MAX_ID: max_id_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DECIDE) && pass)
        begin
            dev_id_reg <= cell_q[0];
            front_reg  <= {data_win[1], data_win[2], data_win[3], data_win[4]};
            back_reg   <= {data_win[5], data_win[6], data_win[7], data_win[8]};
            check_reg  <= cell_q[PACKET_LEN-1];
            speed_reg  <= {data_win[4], data_win[5]};
        end
    end

    assign out_valid     = out_valid_reg;
    assign device_id     = dev_id_reg;
    assign payload_front = front_reg;
    assign payload_back  = back_reg;
    assign check_byte    = check_reg;
    assign speed_value   = $signed(speed_reg);

    // checks
    a_fill_during_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (fill_reg == FILL_W'(PACKET_LEN - 1)))
        else $error("fill count moved during a check");

    a_start_on_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fills) |=> (state_reg == ST_CRC))
        else $error("check did not start on a full window");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> !out_valid_reg)
        else $error("decision reached with a result still held");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DECIDE))
        else $error("result raised outside the decision step");

endmodule

[tb/testbench.sv]
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cpf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned QUIET_SPAN  = 100;

    typedef byte_t byte_list_t [$];

    // one decoded packet as it leaves the framer
    typedef struct {
        byte_t              device_id;
        logic [31:0]        front;
        logic [31:0]        back;
        byte_t              check;
        logic signed [15:0] speed;
    } packet_t;

    // one serial byte waiting to be sent, with its lead-in gap
    typedef struct {
        byte_t       value;
        int unsigned gap;
        bit          hold;
    } rx_beat_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_ID;
    logic [7:0]           cfg_data  = 8'h00;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [7:0]           rx_byte   = 8'h00;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           device_id;
    logic [31:0]          payload_front;
    logic [31:0]          payload_back;
    logic [7:0]           check_byte;
    logic signed [15:0]   speed_value;

    // predictor state
    byte_t       frame_win [PACKET_LEN];
    int unsigned win_fill   = 0;
    byte_t       id_floor   = MIN_ID_RESET;
    byte_t       id_ceiling = MAX_ID_RESET;

    rx_beat_t    rx_pending [$];
    packet_t     packets_due [$];
    int unsigned results_owed   = 0;
    int unsigned stall_left     = 0;
    bit          rx_calm        = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    crc8_checked_packet_framer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .device_id     (device_id),
        .payload_front (payload_front),
        .payload_back  (payload_back),
        .check_byte    (check_byte),
        .speed_value   (speed_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // reflected crc-8, lsb first, over a list of bytes
    function automatic byte_t crc8_lsb_first(input byte_list_t data);
        byte_t crc;
        crc = CRC_INIT;
        foreach (data[i])
        begin
            crc = crc ^ data[i];
            for (int b = 0; b < 8; b++)
            begin
                if (crc[0])
                    crc = (crc >> 1) ^ CRC_POLY;
                else
                    crc = crc >> 1;
            end
        end
        return crc;
    endfunction

    // reported data byte, zero where the position is not a data byte
    function automatic byte_t data_at(input int idx);
        if (idx >= PACKET_LEN - 1)
            return 8'h00;
        return frame_win[idx];
    endfunction

    // push one received byte into the window; returns 1 when a packet is framed
    function automatic bit frame_rx_byte(input byte_t b, output packet_t pkt);
        byte_list_t covered;
        pkt = '{default: '0};
        if (win_fill >= PACKET_LEN)
            win_fill = PACKET_LEN - 1;
        frame_win[win_fill] = b;
        win_fill++;
        if (win_fill < PACKET_LEN)
            return 1'b0;
        for (int i = 0; i < PACKET_LEN - 1; i++)
            covered = {covered, frame_win[i]};
        if (frame_win[0] >= id_floor && frame_win[0] <= id_ceiling &&
            crc8_lsb_first(covered) == frame_win[PACKET_LEN-1])
        begin
            pkt.device_id = frame_win[0];
            pkt.front     = {data_at(1), data_at(2), data_at(3), data_at(4)};
            pkt.back      = {data_at(5), data_at(6), data_at(7), data_at(8)};
            pkt.check     = frame_win[PACKET_LEN-1];
            pkt.speed     = {data_at(4), data_at(5)};
            win_fill = 0;
            return 1'b1;
        end
        // oldest byte drops out
        for (int i = 0; i < PACKET_LEN - 1; i++)
            frame_win[i] = frame_win[i+1];
        win_fill = PACKET_LEN - 1;
        return 1'b0;
    endfunction

    // append the check byte to a packet body
    function automatic byte_list_t sealed(input byte_list_t body);
        byte_list_t frame;
        frame = {body, crc8_lsb_first(body)};
        return frame;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // byte driver
    always @(posedge clk)
    begin : rx_driver
        rx_beat_t next_beat;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (rx_pending.size() == 0)
                in_valid <= 1'b0;
            else if (rx_pending[0].gap != 0)
            begin
                rx_pending[0].gap--;
                in_valid <= 1'b0;
            end
            else if (rx_pending[0].hold && (in_valid || results_owed != 0))
                in_valid <= 1'b0;
            else
            begin
                next_beat = rx_pending.pop_front();
                in_valid <= 1'b1;
                rx_byte  <= next_beat.value;
            end
        end
    end

    // prediction on accepted bytes, checking of accepted packets
    always @(posedge clk)
    begin : packet_monitor
        packet_t     fresh;
        packet_t     want;
        int unsigned hold_for;
        if (rst_n)
        begin
            // register writes land in the predictor copy
            if (cfg_we)
            begin
                if (cfg_index == CFG_MIN_ID)
                    id_floor = cfg_data;
                else if (cfg_index == CFG_MAX_ID)
                    id_ceiling = cfg_data;
            end
            // accepted byte beat
            if (in_valid && !in_stall)
            begin
                if (frame_rx_byte(rx_byte, fresh))
                    packets_due = {packets_due, fresh};
            end
            // accepted packet beat
            if (out_valid && !out_stall)
            begin
                if (packets_due.size() == 0)
                begin
                    $display("%0t: unexpected packet, expected none, got id %h",
                             $time, device_id);
                    mismatch_count++;
                end
                else
                begin
                    want = packets_due.pop_front();
                    report_field("device_id", {24'h0, want.device_id}, {24'h0, device_id});
                    report_field("payload_front", want.front, payload_front);
                    report_field("payload_back", want.back, payload_back);
                    report_field("check_byte", {24'h0, want.check}, {24'h0, check_byte});
                    report_field("speed_value", {16'h0, want.speed}, {16'h0, speed_value});
                end
                if ($urandom_range(0, 7) == 0)
                    rx_calm = !rx_calm;
                hold_for = rx_calm ? 0 : $urandom_range(0, 16);
                stall_left <= hold_for;
                out_stall  <= (hold_for != 0);
            end
            else if (out_valid && stall_left > 1)
                stall_left <= stall_left - 1;
            else if (out_valid)
            begin
                stall_left <= 0;
                out_stall  <= 1'b0;
            end
        end
        results_owed <= packets_due.size();
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_beats(input byte_list_t beats, input bit calm, input bit hold);
        rx_beat_t beat;
        foreach (beats[i])
        begin
            beat.value = beats[i];
            beat.gap   = calm ? 0 : $urandom_range(0, 16);
            beat.hold  = hold && (i == 0);
            rx_pending = {rx_pending, beat};
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input byte_t value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // wait until every byte is sent, every packet is in and the framer is quiet
    task automatic settle();
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_SPAN)
        begin
            @(negedge clk);
            if (rx_pending.size() == 0 && !in_valid && results_owed == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    // mostly well-formed packets, some corrupted, cut short or plain noise
    task automatic random_traffic(input byte_t lo, input byte_t hi, input int unsigned n_bytes);
        byte_list_t  body;
        byte_list_t  frame;
        byte_t       id;
        int unsigned pushed;
        int unsigned roll;
        int unsigned pos;
        int unsigned cut;
        bit          calm;
        pushed = 0;
        calm   = 1'b0;
        @(negedge clk);
        while (pushed < n_bytes)
        begin
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            // device id: mostly in range, edges often, sometimes anything
            roll = $urandom_range(0, 99);
            if (roll < 10)
                id = lo;
            else if (roll < 20)
                id = hi;
            else if (roll < 80 && lo <= hi)
                id = byte_t'($urandom_range(lo, hi));
            else
                id = byte_t'($urandom_range(0, 255));
            body.delete();
            body = {body, id};
            repeat (PACKET_LEN - 2)
                body = {body, byte_t'($urandom_range(0, 255))};
            frame = sealed(body);
            roll = $urandom_range(0, 99);
            if (roll >= 70 && roll < 80)
            begin
                // single bit error anywhere in the packet
                pos = $urandom_range(0, PACKET_LEN - 1);
                frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
            else if (roll >= 80 && roll < 88)
            begin
                cut = $urandom_range(1, PACKET_LEN - 1);
                while (frame.size() > cut)
                    void'(frame.pop_back());
            end
            else if (roll >= 88)
            begin
                frame.delete();
                repeat ($urandom_range(1, 12))
                    frame = {frame, byte_t'($urandom_range(0, 255))};
            end
            queue_beats(frame, calm, pushed == 0 || $urandom_range(0, 24) == 0);
            pushed += frame.size();
        end
    endtask

    task automatic set_id_range(input byte_t lo, input byte_t hi);
        write_reg(CFG_MIN_ID, lo);
        write_reg(CFG_MAX_ID, hi);
    endtask

    // stimulus
    initial
    begin : stimulus
        byte_list_t body;
        byte_t      lo;
        byte_t      hi;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // lowest id with peak positive speed, highest id with peak negative speed
        @(negedge clk);
        body = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'h00};
        queue_beats(sealed(body), 1'b0, 1'b0);
        body = '{8'h04, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'hFF};
        queue_beats(sealed(body), 1'b0, 1'b0);
        random_traffic(MIN_ID_RESET, MAX_ID_RESET, 300);
        settle();

        // every id accepted
        set_id_range(8'h00, 8'hFF);
        random_traffic(8'h00, 8'hFF, 300);
        settle();

        // only id zero
        set_id_range(8'h00, 8'h00);
        random_traffic(8'h00, 8'h00, 280);
        settle();

        // only id 255
        set_id_range(8'hFF, 8'hFF);
        random_traffic(8'hFF, 8'hFF, 280);
        settle();

        // empty id range, nothing may come out
        set_id_range(8'hC8, 8'h64);
        random_traffic(8'hC8, 8'h64, 120);
        settle();

        // some ordinary range
        lo = byte_t'($urandom_range(0, 200));
        hi = lo + byte_t'($urandom_range(0, 55));
        set_id_range(lo, hi);
        random_traffic(lo, hi, 350);
        settle();

        if (mismatch_count == 0 && packets_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/cpf_pkg.sv
hw/rtl/cpf_cell.sv
hw/rtl/cpf_crc.sv
hw/rtl/crc8_checked_packet_framer.sv
tb/testbench.sv
